>>> rtl/double_ended_queue_top_assert.svh
// assertion macros for the deque top level
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int MODE_W         = 2;

    localparam logic [WORD_W-1:0] NEG_ONE = '1;

    // command codes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

    // per-cycle operation broadcast along a cell row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_TRIM
    } t_cell_op;

endpackage

`default_nettype wire

>>> rtl/deq_if.sv
`default_nettype none

interface deq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::MODE_W-1:0]        mode;
    logic signed [deq_pkg::WORD_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int CNT_W = 11
);
    logic                              valid;
    logic                              ready;
    logic signed [deq_pkg::WORD_W-1:0] popped;
    logic                              pop_on_empty;
    logic                              push_dropped;
    logic [CNT_W-1:0]                  count;
    logic                              is_empty;
    logic signed [deq_pkg::WORD_W-1:0] front_word;
    logic signed [deq_pkg::WORD_W-1:0] back_word;

    modport source (output valid, output popped, output pop_on_empty, output push_dropped,
                    output count, output is_empty, output front_word, output back_word,
                    input ready);
    modport sink   (input valid, input popped, input pop_on_empty, input push_dropped,
                    input count, input is_empty, input front_word, input back_word,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/deq_cell.sv
`default_nettype none

module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire deq_pkg::t_cell_op     i_op,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_left_data,
    input  wire logic                  i_left_vld,
    input  wire logic [DATA_WIDTH-1:0] i_right_data,
    input  wire logic                  i_right_vld,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_vld
);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_vld, n_vld;

    always_comb begin
        n_data = r_data;
        n_vld  = r_vld;
        case (i_op)
            deq_pkg::CELL_INSERT: begin
                n_data = i_left_data;
                n_vld  = i_left_vld;
            end
            deq_pkg::CELL_APPEND: begin
                // first empty slot takes the new word
                if (!r_vld && i_left_vld) begin
                    n_data = i_word;
                    n_vld  = 1'b1;
                end
            end
            deq_pkg::CELL_REMOVE: begin
                n_data = i_right_data;
                n_vld  = i_right_vld;
            end
            deq_pkg::CELL_TRIM: begin
                // last occupied slot lets go
                if (r_vld && !i_right_vld) begin
                    n_vld = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_vld  = r_vld;

endmodule

`default_nettype wire

>>> rtl/deq_row.sv
`default_nettype none

module deq_row #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire deq_pkg::t_cell_op     i_op,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    output logic      [DATA_WIDTH-1:0] o_word0,
    output logic      [DATA_WIDTH-1:0] o_word1,
    output logic                       o_vld0
);

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic                  w_vld  [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data, w_right_data;
        logic                  w_left_vld, w_right_vld;

        // the open end of the row sees the incoming word as its left neighbour
        if (k == 0) begin : g_head
            assign w_left_data = i_word;
            assign w_left_vld  = 1'b1;
        end else begin : g_body
            assign w_left_data = w_data[k-1];
            assign w_left_vld  = w_vld[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_right_data = '0;
            assign w_right_vld  = 1'b0;
        end else begin : g_mid
            assign w_right_data = w_data[k+1];
            assign w_right_vld  = w_vld[k+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_word       (i_word),
            .i_left_data  (w_left_data),
            .i_left_vld   (w_left_vld),
            .i_right_data (w_right_data),
            .i_right_vld  (w_right_vld),
            .o_data       (w_data[k]),
            .o_vld        (w_vld[k])
        );
    end

    assign o_word0 = w_data[0];
    assign o_word1 = w_data[1];
    assign o_vld0  = w_vld[0];

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_top.sv
// result: registered; a beat appears in the cycle after its command beat is accepted
// throughput: one command per cycle while result beats are taken; the output register
// frees when its beat is taken; both rows update all cells at the accepting edge, so no
// operation stalls on storage; reset: synchronous active-low i_rst_n empties the queue
// (cell valid flags and occupancy cleared, no clearing pass, stored words left as they are)
`default_nettype none

`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OW    = deq_pkg::WORD_W;

    // two rows of cells hold the same sequence:
    //   front row: cell 0 is the front word, growing towards the back
    //   back row:  cell 0 is the back word, growing towards the front
    // every operation is then a shift or a local edit at one end of each row,
    // so front, back and their neighbours are always at fixed cells

    logic [CNT_W-1:0]      r_count, n_count;

    logic                  w_accept;
    logic                  w_push;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_one;
    logic [DATA_WIDTH-1:0] w_word;

    logic [DATA_WIDTH-1:0] w_f0, w_f1, w_b0, w_b1;
    logic                  w_f_vld0, w_b_vld0;

    deq_pkg::t_cell_op     w_f_op, w_b_op;
    deq_pkg::t_cell_op     w_f_op_go, w_b_op_go;

    logic [DATA_WIDTH-1:0] w_pop_val;
    logic                  w_pop_none;
    logic                  w_pop_empty;
    logic                  w_dropped;
    logic [DATA_WIDTH-1:0] w_front, w_back;
    logic                  w_none;

    // output register
    logic                  r_rsp_valid;
    logic [OW-1:0]         r_rsp_popped;
    logic                  r_rsp_pop_empty;
    logic                  r_rsp_dropped;
    logic [CNT_W-1:0]      r_rsp_count;
    logic                  r_rsp_is_empty;
    logic [OW-1:0]         r_rsp_front;
    logic [OW-1:0]         r_rsp_back;

    // a new command is taken whenever the result slot is free or being drained
    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_push  = (i_cmd.mode == deq_pkg::MODE_PUSH_BACK)
                  || (i_cmd.mode == deq_pkg::MODE_PUSH_FRONT);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_one   = (r_count == CNT_W'(1));

    // stored form keeps the low DATA_WIDTH bits
    assign w_word = DATA_WIDTH'($unsigned(i_cmd.value));

    // command decode: row operations, popped word and the ends after the beat
    always_comb begin
        w_f_op      = deq_pkg::CELL_HOLD;
        w_b_op      = deq_pkg::CELL_HOLD;
        n_count     = r_count;
        w_pop_val   = w_f0;
        w_pop_none  = 1'b1;
        w_pop_empty = 1'b0;
        w_dropped   = 1'b0;
        w_front     = w_f0;
        w_back      = w_b0;
        w_none      = w_empty;
        case (i_cmd.mode)
            deq_pkg::MODE_PUSH_BACK: begin
                if (w_full) begin
                    w_dropped = 1'b1;
                end else begin
                    w_f_op  = deq_pkg::CELL_APPEND;
                    w_b_op  = deq_pkg::CELL_INSERT;
                    n_count = CNT_W'(r_count + 1'b1);
                    w_front = w_empty ? w_word : w_f0;
                    w_back  = w_word;
                    w_none  = 1'b0;
                end
            end
            deq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    w_dropped = 1'b1;
                end else begin
                    w_f_op  = deq_pkg::CELL_INSERT;
                    w_b_op  = deq_pkg::CELL_APPEND;
                    n_count = CNT_W'(r_count + 1'b1);
                    w_front = w_word;
                    w_back  = w_empty ? w_word : w_b0;
                    w_none  = 1'b0;
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (w_empty) begin
                    w_pop_empty = 1'b1;
                end else begin
                    w_f_op     = deq_pkg::CELL_REMOVE;
                    w_b_op     = deq_pkg::CELL_TRIM;
                    n_count    = CNT_W'(r_count - 1'b1);
                    w_pop_val  = w_f0;
                    w_pop_none = 1'b0;
                    // next word in from the front becomes the new front
                    w_front    = w_f1;
                    w_back     = w_b0;
                    w_none     = w_one;
                end
            end
            deq_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    w_pop_empty = 1'b1;
                end else begin
                    w_f_op     = deq_pkg::CELL_TRIM;
                    w_b_op     = deq_pkg::CELL_REMOVE;
                    n_count    = CNT_W'(r_count - 1'b1);
                    w_pop_val  = w_b0;
                    w_pop_none = 1'b0;
                    w_front    = w_f0;
                    w_back     = w_b1;
                    w_none     = w_one;
                end
            end
            default: begin
            end
        endcase
    end

    // rows only move on an accepted beat
    assign w_f_op_go = w_accept ? w_f_op : deq_pkg::CELL_HOLD;
    assign w_b_op_go = w_accept ? w_b_op : deq_pkg::CELL_HOLD;

    deq_row #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_f_op_go),
        .i_word  (w_word),
        .o_word0 (w_f0),
        .o_word1 (w_f1),
        .o_vld0  (w_f_vld0)
    );

    deq_row #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_b_op_go),
        .i_word  (w_word),
        .o_word0 (w_b0),
        .o_word1 (w_b1),
        .o_vld0  (w_b_vld0)
    );

    // occupancy and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // result payload; words are sign-extended from the stored width
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp_popped    <= w_pop_none ? deq_pkg::NEG_ONE : OW'($signed(w_pop_val));
            r_rsp_pop_empty <= w_pop_empty;
            r_rsp_dropped   <= w_dropped;
            r_rsp_count     <= n_count;
            r_rsp_is_empty  <= w_none;
            r_rsp_front     <= w_none ? deq_pkg::NEG_ONE : OW'($signed(w_front));
            r_rsp_back      <= w_none ? deq_pkg::NEG_ONE : OW'($signed(w_back));
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.popped       = r_rsp_popped;
    assign o_rsp.pop_on_empty = r_rsp_pop_empty;
    assign o_rsp.push_dropped = r_rsp_dropped;
    assign o_rsp.count        = r_rsp_count;
    assign o_rsp.is_empty     = r_rsp_is_empty;
    assign o_rsp.front_word   = r_rsp_front;
    assign o_rsp.back_word    = r_rsp_back;

    // the end cells of both rows are occupied exactly when the queue is not empty
    `DEQ_ASSERT_IMP(a_end_cells_track_count, 1'b1, (w_f_vld0 == (r_count != '0)) && (w_b_vld0 == (r_count != '0)), "end cell occupancy disagrees with count")

    // a push with room grows the queue by one
    `DEQ_ASSERT_NXT(a_push_grows_count, w_accept && w_push && !w_full, r_count == $past(r_count) + 1'b1, "accepted push did not grow count")

    // a pop on an empty queue leaves it empty and flags it
    `DEQ_ASSERT_NXT(a_pop_empty_flagged, w_accept && !w_push && w_empty, (r_count == '0) && r_rsp_pop_empty, "pop on empty queue mishandled")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int QDEPTH         = deq_pkg::DEPTH_DEF;
    localparam int CNT_W          = 11;
    localparam int WORD_W         = deq_pkg::WORD_W;
    localparam int MODE_W         = deq_pkg::MODE_W;
    localparam int DIR_ROWS       = 18;
    localparam int RANDOM_ITEMS   = 1880;
    localparam int PHASE_ITEMS    = 500;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int FULL_BURST     = 20;
    localparam int TAIL_CYCLES    = 16;

    // one result beat, field for field as the block presents it
    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic                     pop_on_empty;
        logic                     push_dropped;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
    } t_deq_result;

    // directed row: command plus, where obvious, the result typed in by hand
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
        bit                       typed;
        t_deq_result              want;
    } t_dir_row;

    // shape of the random traffic: fill right up, sit at full, drain, then mix
    typedef enum {
        FILL_UP,
        HOLD_FULL,
        DRAIN,
        MIXED_OPS
    } t_fill_stage;

    localparam t_deq_result EMPTY_RESULT = '{deq_pkg::NEG_ONE, 1'b1, 1'b0, '0, 1'b1,
                                             deq_pkg::NEG_ONE, deq_pkg::NEG_ONE};

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_cmd_if                 cmd_bus ();
    deq_rsp_if #(.CNT_W(CNT_W)) rsp_bus ();

    double_ended_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow deque: ring store, head pointer and occupancy
    logic signed [WORD_W-1:0] shadow_store [QDEPTH];
    int                       shadow_head;
    int                       shadow_occ;

    t_deq_result pending_results [$];
    t_dir_row    dir_rows [DIR_ROWS];
    int          mismatch_count;

    // idling pattern in force: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int idle_phase;
    // the driver arms the long receiver hold-off, the receiver serves it once
    bit hold_armed;

    function automatic int ring_slot(int offset);
        return (shadow_head + offset) % QDEPTH;
    endfunction

    // apply one command to the shadow deque and return the result it should give
    function automatic t_deq_result deque_apply(logic [MODE_W-1:0] mode,
                                                logic signed [WORD_W-1:0] value);
        t_deq_result r;
        r        = '0;
        r.popped = deq_pkg::NEG_ONE;
        case (mode)
            deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
                if (shadow_occ >= QDEPTH) begin
                    r.push_dropped = 1'b1;
                end else if (mode == deq_pkg::MODE_PUSH_BACK) begin
                    shadow_store[ring_slot(shadow_occ)] = value;
                    shadow_occ++;
                end else begin
                    shadow_head = ring_slot(QDEPTH - 1);
                    shadow_store[shadow_head] = value;
                    shadow_occ++;
                end
            end
            default: begin
                if (shadow_occ == 0) begin
                    r.pop_on_empty = 1'b1;
                end else if (mode == deq_pkg::MODE_POP_FRONT) begin
                    r.popped    = shadow_store[shadow_head];
                    shadow_head = ring_slot(1);
                    shadow_occ--;
                end else begin
                    r.popped = shadow_store[ring_slot(shadow_occ - 1)];
                    shadow_occ--;
                end
            end
        endcase
        r.count    = CNT_W'(shadow_occ);
        r.is_empty = (shadow_occ == 0);
        if (shadow_occ == 0) begin
            r.front_word = deq_pkg::NEG_ONE;
            r.back_word  = deq_pkg::NEG_ONE;
        end else begin
            r.front_word = shadow_store[shadow_head];
            r.back_word  = shadow_store[ring_slot(shadow_occ - 1)];
        end
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase)
            1:       return $urandom_range(99) < 83;
            3:       return $urandom_range(99) < 18;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase)
            2:       return $urandom_range(99) < 83;
            3:       return $urandom_range(99) < 18;
            default: return 1'b0;
        endcase
    endfunction

    // push with the given chance in percent, else pop; end of the deque at random
    function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
        return $urandom_range(1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_BACK;
    endfunction

    // mostly random words, now and then an extreme
    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return deq_pkg::NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    // offer one command beat and hold it until taken; the expectation is queued
    // at the falling edge that sees valid and ready, just ahead of the accepting edge
    task automatic put_cmd(logic [MODE_W-1:0] mode, logic signed [WORD_W-1:0] value,
                           bit typed, t_deq_result want);
        t_deq_result predicted;
        bit          taken;
        while (sender_idles()) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.mode  <= mode;
        cmd_bus.value <= value;
        do begin
            @(negedge i_clk);
            taken = cmd_bus.ready;
            if (taken) begin
                predicted = deque_apply(mode, value);
                pending_results.insert(pending_results.size(), typed ? want : predicted);
            end
            @(posedge i_clk);
        end while (!taken);
    endtask

    // drop valid and wait until every result beat so far has come back
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic report_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver and scoreboard: ready is driven at the rising edge, the beat
    // is sampled at the falling edge so nothing hinges on event order
    initial begin
        t_deq_result want;
        int          hold_left;
        bit          hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_served) begin
                hold_left   = RX_HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                // long hold-off so the output register backs up and stalls the input
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= !receiver_stalls();
            end
            @(negedge i_clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat, expected none, actual %h %b %b %0d %b %h %h",
                             $time, rsp_bus.popped, rsp_bus.pop_on_empty, rsp_bus.push_dropped,
                             rsp_bus.count, rsp_bus.is_empty, rsp_bus.front_word,
                             rsp_bus.back_word);
                    mismatch_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    report_field("popped", want.popped, rsp_bus.popped);
                    report_field("pop_on_empty", 32'(want.pop_on_empty), 32'(rsp_bus.pop_on_empty));
                    report_field("push_dropped", 32'(want.push_dropped), 32'(rsp_bus.push_dropped));
                    report_field("count", 32'(want.count), 32'(rsp_bus.count));
                    report_field("is_empty", 32'(want.is_empty), 32'(rsp_bus.is_empty));
                    report_field("front_word", want.front_word, rsp_bus.front_word);
                    report_field("back_word", want.back_word, rsp_bus.back_word);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_fill_stage       stage;
        int                n_items;
        int                burst_left;
        int                next_phase;
        logic [MODE_W-1:0] mode;

        mismatch_count = 0;
        idle_phase     = 0;
        hold_armed     = 1'b0;
        shadow_head    = 0;
        shadow_occ     = 0;
        foreach (shadow_store[i]) shadow_store[i] = '0;

        i_rst_n       <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.mode  <= deq_pkg::MODE_PUSH_BACK;
        cmd_bus.value <= '0;

        // directed rows: empty pops, extreme words at both ends, ordering, bit patterns
        dir_rows = '{
            '{deq_pkg::MODE_POP_FRONT, 32'sh0, 1'b1, EMPTY_RESULT},
            '{deq_pkg::MODE_POP_BACK, 32'sh1234_5678, 1'b1, EMPTY_RESULT},
            '{deq_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1,
              '{deq_pkg::NEG_ONE, 1'b0, 1'b0, 11'd1, 1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
            '{deq_pkg::MODE_PUSH_FRONT, 32'sh8000_0000, 1'b1,
              '{deq_pkg::NEG_ONE, 1'b0, 1'b0, 11'd2, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF}},
            '{deq_pkg::MODE_PUSH_BACK, deq_pkg::NEG_ONE, 1'b0, '0},
            '{deq_pkg::MODE_PUSH_FRONT, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_BACK, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_FRONT, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_FRONT, deq_pkg::NEG_ONE, 1'b0, '0},
            '{deq_pkg::MODE_POP_BACK, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_BACK, 32'sh0, 1'b1, EMPTY_RESULT},
            '{deq_pkg::MODE_PUSH_FRONT, 32'sh5555_5555, 1'b0, '0},
            '{deq_pkg::MODE_PUSH_FRONT, 32'shAAAA_AAAA, 1'b0, '0},
            '{deq_pkg::MODE_POP_BACK, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_BACK, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_PUSH_BACK, 32'sh1234_5678, 1'b0, '0},
            '{deq_pkg::MODE_POP_FRONT, 32'sh0, 1'b0, '0},
            '{deq_pkg::MODE_POP_FRONT, 32'sh0, 1'b1, EMPTY_RESULT}
        };

        // reset held low from the start, released at a rising edge
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            put_cmd(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

        // sender pause until the directed results are all back
        drain_results();

        // random part: fill to full (wrapping the ring), push into a full deque,
        // then drain; mixed traffic takes over should the deque run empty
        stage      = FILL_UP;
        n_items    = 0;
        burst_left = FULL_BURST;
        while (n_items < RANDOM_ITEMS) begin
            next_phase = (n_items < 3 * PHASE_ITEMS) ? n_items / PHASE_ITEMS : 3;
            if (next_phase != idle_phase) begin
                // change idling pattern only with nothing in flight
                drain_results();
                idle_phase = next_phase;
            end
            if (n_items == 100)
                hold_armed = 1'b1;

            case (stage)
                FILL_UP:   mode = pick_mode(97);
                HOLD_FULL: mode = pick_mode(75);
                DRAIN:     mode = pick_mode(3);
                default:   mode = pick_mode(50);
            endcase
            put_cmd(mode, pick_value(), 1'b0, '0);
            n_items++;

            case (stage)
                FILL_UP:   if (shadow_occ == QDEPTH) stage = HOLD_FULL;
                HOLD_FULL: begin
                    burst_left--;
                    if (burst_left == 0) stage = DRAIN;
                end
                DRAIN:     if (shadow_occ == 0) stage = MIXED_OPS;
                default:   ;
            endcase
        end

        // wind down: wait for the last beats, then keep the clock running for strays
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("** double_ended_queue_top: PASSED **");
        else
            $display("** double_ended_queue_top: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("** double_ended_queue_top: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cell.sv
rtl/deq_row.sv
rtl/double_ended_queue_top.sv
tb/sv/tb.sv
